// ===== src/html_article_text_filter_core_assert.svh =====
// Assertion macros for the filter RTL.
`ifndef HTML_ARTICLE_TEXT_FILTER_CORE_ASSERT_SVH
`define HTML_ARTICLE_TEXT_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HATF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hatf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HATF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hatf: next-cycle check failed");

`endif

// ===== src/hatf_pkg.sv =====
package hatf_pkg;

   // Lookahead depth and the widths that follow from it.
   localparam int WIN_DEPTH = 34;
   localparam int SKIP_W    = 6;

   typedef logic [0:WIN_DEPTH-1][7:0] win_type;
   typedef logic [0:WIN_DEPTH-1]      occ_type;
   typedef logic [SKIP_W-1:0]         skip_type;

   // Conversion phase.
   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_CONVERT = 2'd1,
      PH_STOPPED = 2'd2
   } phase_type;

   // One result as it enters the result register.
   typedef struct packed {
      logic       valid;
      logic       twice;
      logic [7:0] text;
      logic       status;
      logic       final_res;
   } res_type;

   // Characters.
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Status codes.
   localparam logic ST_TEXT    = 1'b0;
   localparam logic ST_NO_MARK = 1'b1;

   // Patterns, first character at index zero, padded with zero bytes.
   localparam win_type PAT_OPEN   = "<div class=\"paragraphs-container\">";
   localparam win_type PAT_TRANS  = {"<h3>Transcript</h3>", {15{8'h00}}};
   localparam win_type PAT_SCR_O  = {"<script", {27{8'h00}}};
   localparam win_type PAT_SCR_C  = {"</script>", {25{8'h00}}};
   localparam win_type PAT_P_O    = {"<p>", {31{8'h00}}};
   localparam win_type PAT_H3_O   = {"<h3>", {30{8'h00}}};
   localparam win_type PAT_P_C    = {"</p>", {30{8'h00}}};
   localparam win_type PAT_H3_C   = {"</h3>", {29{8'h00}}};
   localparam win_type PAT_BR     = {"<br", {31{8'h00}}};
   localparam win_type PAT_HR     = {"<hr", {31{8'h00}}};
   localparam win_type PAT_AMP    = {"&amp;", {29{8'h00}}};
   localparam win_type PAT_QUOT   = {"&quot;", {28{8'h00}}};
   localparam win_type PAT_N39    = {"&#39;", {29{8'h00}}};
   localparam win_type PAT_APOS   = {"&apos;", {28{8'h00}}};
   localparam win_type PAT_NBSP   = {"&nbsp;", {28{8'h00}}};

   // Pattern lengths.
   localparam skip_type LEN_OPEN  = 6'd34;
   localparam skip_type LEN_TRANS = 6'd19;
   localparam skip_type LEN_SCR_O = 6'd7;
   localparam skip_type LEN_SCR_C = 6'd9;
   localparam skip_type LEN_3     = 6'd3;
   localparam skip_type LEN_4     = 6'd4;
   localparam skip_type LEN_5     = 6'd5;
   localparam skip_type LEN_6     = 6'd6;

   // True when the first len window bytes are present and equal the pattern.
   function automatic logic head_match(input win_type win, input occ_type occ,
                                       input win_type pat, input skip_type len);
      logic hit;
      hit = occ[len - 6'd1];
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if ((i < int'(len)) && (win[i] != pat[i])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ===== src/html_article_text_filter_core.sv =====
// A byte is decided once 33 later bytes (or the document end) are in the window,
// and its result appears in the cycle after that decision.
// Throughput: one byte per cycle unless stalled; a rule tag holds the head for its second newline.
// Document end: the pending window drains, then the final item is loaded.
// Reset is synchronous and active high; it clears occupancy, parse state and the result register's valid flags.
module html_article_text_filter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_doc_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_status,
   output logic       rsp_final_res
);

`include "html_article_text_filter_core_assert.svh"

   hatf_pkg::win_type win;
   hatf_pkg::occ_type occ;
   hatf_pkg::res_type head_res;
   hatf_pkg::res_type load;

   logic drain_ff, drain_in;
   logic out_free;
   logic proc, head_free, push, pad, shift, consume, fin_evt;
   logic searching;

   // Handshake and window control. The head is decided whenever it holds a byte
   // and the result register can take what it yields.
   assign proc      = occ[0] && out_free;
   assign head_free = !occ[0] || out_free;
   assign req_stall = drain_ff || !head_free;
   assign push      = req_valid && !req_stall;
   assign pad       = drain_ff && head_free;
   assign shift     = push || pad;
   assign consume   = proc && !shift;
   assign fin_evt   = drain_ff && (occ == '0) && out_free;

   // Draining runs from the last byte until the final item is loaded.
   always_comb begin
      drain_in = drain_ff;
      if (fin_evt) begin
         drain_in = 1'b0;
      end else if (push && req_doc_end) begin
         drain_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
      end else begin
         drain_ff <= drain_in;
      end
   end

   // Select the head result or the closing item of the document.
   always_comb begin
      load = head_res;
      if (fin_evt) begin
         load.valid     = 1'b1;
         load.twice     = 1'b0;
         load.text      = searching ? hatf_pkg::CH_NUL : hatf_pkg::CH_NL;
         load.status    = searching ? hatf_pkg::ST_NO_MARK : hatf_pkg::ST_TEXT;
         load.final_res = 1'b1;
      end
   end

   hatf_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (shift),
      .push    (push),
      .consume (consume),
      .in_byte (req_in_byte),
      .win     (win),
      .occ     (occ)
   );

   hatf_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .proc      (proc),
      .clear     (fin_evt),
      .win       (win),
      .occ       (occ),
      .head_res  (head_res),
      .searching (searching)
   );

   hatf_out u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .rsp_stall     (rsp_stall),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_text_byte (rsp_text_byte),
      .rsp_status    (rsp_status),
      .rsp_final_res (rsp_final_res)
   );

   // Outside a drain, a head byte is only decided with the whole window present.
   `HATF_ASSERT_NOW(a_full_window, clock, reset, occ[0] && !drain_ff, &occ)
   // The missing-marker status only ever comes on the last item of a document.
   `HATF_ASSERT_NOW(a_status_final, clock, reset, rsp_valid && rsp_status, rsp_final_res)
   // Loading the final item ends the drain and leaves an empty window.
   `HATF_ASSERT_NEXT(a_fin_clears, clock, reset, fin_evt, !drain_ff && (occ == '0))

endmodule

// ===== src/hatf_window.sv =====
module hatf_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               push,
   input  logic               consume,
   input  logic [7:0]         in_byte,
   output hatf_pkg::win_type  win,
   output hatf_pkg::occ_type  occ
);

   hatf_pkg::win_type win_ff, win_in;
   hatf_pkg::occ_type occ_ff, occ_in;

   // Bytes enter at the tail and move one place toward the head on each shift.
   // A shift without a new byte brings in an empty place at the tail.
   always_comb begin
      win_in = win_ff;
      occ_in = occ_ff;
      if (shift) begin
         win_in = {win_ff[1:hatf_pkg::WIN_DEPTH-1], in_byte};
         occ_in = {occ_ff[1:hatf_pkg::WIN_DEPTH-1], push};
      end else if (consume) begin
         occ_in[0] = 1'b0;
      end
   end

   // Window data needs no reset; only occupancy is cleared.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign win = win_ff;
   assign occ = occ_ff;

endmodule

// ===== src/hatf_parse.sv =====
module hatf_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               proc,
   input  logic               clear,
   input  hatf_pkg::win_type  win,
   input  hatf_pkg::occ_type  occ,
   output hatf_pkg::res_type  head_res,
   output logic               searching
);

   hatf_pkg::phase_type phase_ff, phase_in;
   logic                tag_ff, tag_in;
   logic                script_ff, script_in;
   logic                close_ff, close_in;
   hatf_pkg::skip_type  skip_ff, skip_in;

   logic [7:0] c;
   logic m_open, m_trans, m_scr_o, m_scr_c, m_line, m_hr;
   logic m_amp, m_quot, m_n39, m_apos, m_nbsp;

   // Parallel compares against the head of the window.
   assign c       = win[0];
   assign m_open  = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_OPEN, hatf_pkg::LEN_OPEN);
   assign m_trans = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_TRANS, hatf_pkg::LEN_TRANS);
   assign m_scr_o = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_SCR_O, hatf_pkg::LEN_SCR_O);
   assign m_scr_c = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_SCR_C, hatf_pkg::LEN_SCR_C);
   assign m_line  = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_P_O, hatf_pkg::LEN_3)
                 || hatf_pkg::head_match(win, occ, hatf_pkg::PAT_H3_O, hatf_pkg::LEN_4)
                 || hatf_pkg::head_match(win, occ, hatf_pkg::PAT_P_C, hatf_pkg::LEN_4)
                 || hatf_pkg::head_match(win, occ, hatf_pkg::PAT_H3_C, hatf_pkg::LEN_5)
                 || hatf_pkg::head_match(win, occ, hatf_pkg::PAT_BR, hatf_pkg::LEN_3);
   assign m_hr    = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_HR, hatf_pkg::LEN_3);
   assign m_amp   = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_AMP, hatf_pkg::LEN_5);
   assign m_quot  = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_QUOT, hatf_pkg::LEN_6);
   assign m_n39   = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_N39, hatf_pkg::LEN_5);
   assign m_apos  = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_APOS, hatf_pkg::LEN_6);
   assign m_nbsp  = hatf_pkg::head_match(win, occ, hatf_pkg::PAT_NBSP, hatf_pkg::LEN_6);

   // Decide on the head byte and update the parse state.
   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      script_in = script_ff;
      close_in  = close_ff;
      skip_in   = skip_ff;
      head_res  = '0;
      if (clear) begin
         phase_in  = hatf_pkg::PH_SEARCH;
         tag_in    = 1'b0;
         script_in = 1'b0;
         close_in  = 1'b0;
         skip_in   = '0;
      end else if (proc) begin
         case (phase_ff)
            hatf_pkg::PH_SEARCH: begin
               if (m_open) begin
                  phase_in = hatf_pkg::PH_CONVERT;
                  skip_in  = hatf_pkg::LEN_OPEN - 6'd1;
               end
            end
            hatf_pkg::PH_CONVERT: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 6'd1;
               end else if (close_ff) begin
                  if (c == hatf_pkg::CH_GT) begin
                     close_in = 1'b0;
                  end
               end else if (m_trans) begin
                  phase_in = hatf_pkg::PH_STOPPED;
               end else if (!script_ff && m_scr_o) begin
                  script_in = 1'b1;
                  skip_in   = hatf_pkg::LEN_SCR_O - 6'd1;
               end else if (script_ff) begin
                  if (m_scr_c) begin
                     script_in = 1'b0;
                     skip_in   = hatf_pkg::LEN_SCR_C - 6'd1;
                  end
               end else if (m_line || m_hr) begin
                  head_res.valid = 1'b1;
                  head_res.twice = !m_line;
                  head_res.text  = hatf_pkg::CH_NL;
                  close_in       = 1'b1;
               end else if (c == hatf_pkg::CH_LT) begin
                  tag_in = 1'b1;
               end else if (c == hatf_pkg::CH_GT) begin
                  tag_in = 1'b0;
               end else if (!tag_ff) begin
                  head_res.valid = 1'b1;
                  if (m_amp) begin
                     head_res.text = hatf_pkg::CH_AMP;
                     skip_in       = hatf_pkg::LEN_5 - 6'd1;
                  end else if (m_quot) begin
                     head_res.text = hatf_pkg::CH_QUOT;
                     skip_in       = hatf_pkg::LEN_6 - 6'd1;
                  end else if (m_n39) begin
                     head_res.text = hatf_pkg::CH_APOS;
                     skip_in       = hatf_pkg::LEN_5 - 6'd1;
                  end else if (m_apos) begin
                     head_res.text = hatf_pkg::CH_APOS;
                     skip_in       = hatf_pkg::LEN_6 - 6'd1;
                  end else if (m_nbsp) begin
                     head_res.text = hatf_pkg::CH_SPACE;
                     skip_in       = hatf_pkg::LEN_6 - 6'd1;
                  end else begin
                     head_res.text = c;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hatf_pkg::PH_SEARCH;
         tag_ff    <= 1'b0;
         script_ff <= 1'b0;
         close_ff  <= 1'b0;
         skip_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         script_ff <= script_in;
         close_ff  <= close_in;
         skip_ff   <= skip_in;
      end
   end

   assign searching = (phase_ff == hatf_pkg::PH_SEARCH);

endmodule

// ===== src/hatf_out.sv =====
module hatf_out (
   input  logic               clock,
   input  logic               reset,
   input  hatf_pkg::res_type  load,
   input  logic               rsp_stall,
   output logic               out_free,
   output logic               rsp_valid,
   output logic [7:0]         rsp_text_byte,
   output logic               rsp_status,
   output logic               rsp_final_res
);

   logic       valid_ff, valid_in;
   logic       dup_ff, dup_in;
   logic [7:0] text_ff, text_in;
   logic       status_ff, status_in;
   logic       final_ff, final_in;
   logic       take;

   // The register is free when empty or when its last copy leaves this cycle.
   assign take     = valid_ff && !rsp_stall;
   assign out_free = !valid_ff || (take && !dup_ff);

   // A doubled newline stays for a second item before the register frees.
   always_comb begin
      valid_in  = valid_ff;
      dup_in    = dup_ff;
      text_in   = text_ff;
      status_in = status_ff;
      final_in  = final_ff;
      if (load.valid) begin
         valid_in  = 1'b1;
         dup_in    = load.twice;
         text_in   = load.text;
         status_in = load.status;
         final_in  = load.final_res;
      end else if (take) begin
         if (dup_ff) begin
            dup_in = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dup_ff   <= dup_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      text_ff   <= text_in;
      status_ff <= status_in;
      final_ff  <= final_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_byte = text_ff;
   assign rsp_status    = status_ff;
   assign rsp_final_res = final_ff;

endmodule
